### rtl/iwrc_pkg.sv
// Shared types and constants for the identity window residue counter.
package iwrc_pkg;

  localparam int unsigned SYMBOL_W     = 8;
  localparam int unsigned THRESH_W     = 16;
  localparam int unsigned COUNT_W      = 13;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd26214;

  // Strobes from the sequencer to the window judge.
  typedef struct packed {
    logic first_en;
    logic last_en;
    logic check_en;
    logic clear;
  } judge_ctrl_t;

endpackage

### rtl/iwrc_col_if.sv
// Column channel: one alignment column per word.
interface iwrc_col_if;
  logic                           valid;
  logic                           ready;
  logic                           present_a;
  logic                           present_b;
  logic [iwrc_pkg::SYMBOL_W-1:0]  symbol_a;
  logic [iwrc_pkg::SYMBOL_W-1:0]  symbol_b;
  logic                           last_column;

  modport source (output valid, present_a, present_b, symbol_a, symbol_b, last_column,
                  input ready);
  modport sink   (input valid, present_a, present_b, symbol_a, symbol_b, last_column,
                  output ready);
endinterface

### rtl/iwrc_res_if.sv
// Result channel: one count word per alignment.
interface iwrc_res_if;
  logic                          valid;
  logic                          ready;
  logic [iwrc_pkg::COUNT_W-1:0]  tagged_count;
  logic                          column_overflow;

  modport source (output valid, tagged_count, column_overflow, input ready);
  modport sink   (input valid, tagged_count, column_overflow, output ready);
endinterface

### rtl/iwrc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module iwrc_ram #(
  parameter int unsigned WIDTH = 13,
  parameter int unsigned DEPTH = 21
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/iwrc_judge.sv
// Window judge: span multiply, identity test and union-of-intervals count.
module iwrc_judge #(
  parameter int unsigned CNT_W = 13,
  parameter int unsigned J_W   = 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  iwrc_pkg::judge_ctrl_t         ctrl_i,
  input  logic [CNT_W-1:0]              rdata_i,
  input  logic [J_W-1:0]                j_i,
  input  logic [iwrc_pkg::THRESH_W-1:0] thr_i,
  output logic                          pass_o,
  output logic [CNT_W-1:0]              tagged_o
);

  localparam int unsigned PROD_W = iwrc_pkg::THRESH_W + CNT_W;
  localparam int unsigned LHS_W  = J_W + 1 + iwrc_pkg::THRESH_W;
  localparam int unsigned CMP_W  = (PROD_W > LHS_W) ? PROD_W : LHS_W;

  logic [CNT_W-1:0]  first_q, last_q;
  logic [PROD_W-1:0] prod_q;
  logic [CNT_W-1:0]  cov_q, cov_d;
  logic [CNT_W-1:0]  tagged_q, tagged_d;
  logic [CNT_W-1:0]  span;
  logic [CNT_W-1:0]  from;
  logic [J_W:0]      jp1;
  logic [CMP_W-1:0]  lhs;

  assign span = rdata_i - first_q + CNT_W'(1);
  assign jp1  = {1'b0, j_i} + {{J_W{1'b0}}, 1'b1};
  assign lhs  = CMP_W'({jp1, {iwrc_pkg::THRESH_W{1'b0}}});
  assign pass_o = lhs > CMP_W'(prod_q);
  assign from = (first_q > cov_q) ? first_q : cov_q + CNT_W'(1);

  always_comb begin
    cov_d    = cov_q;
    tagged_d = tagged_q;
    if (ctrl_i.clear) begin
      cov_d    = '0;
      tagged_d = '0;
    end else if (ctrl_i.check_en && pass_o && (last_q > cov_q)) begin
      // Starts never decrease, so only the part beyond the covered end is new.
      tagged_d = tagged_q + (last_q - from) + CNT_W'(1);
      cov_d    = last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cov_q    <= '0;
      tagged_q <= '0;
    end else begin
      cov_q    <= cov_d;
      tagged_q <= tagged_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.first_en) begin
      first_q <= rdata_i;
    end
    if (ctrl_i.last_en) begin
      last_q <= rdata_i;
      prod_q <= PROD_W'(thr_i) * PROD_W'(span);
    end
  end

  assign tagged_o = tagged_q;

endmodule

### rtl/identity_window_residue_counter_top.sv
// Top level: column sequencer, match position ring and window judge.
// A column that starts no judgement leaves the sequencer ready for the next; a judgement
// reads the first match, then per window width tried reads the partner, loads and checks.
// The result follows the last column after the remaining judgements and the emit step.
// Throughput is set by the single read port of the ring, one partner read per window.
// Reset clears all counters and the threshold returns to 0.4; the ring needs no clearing.
module identity_window_residue_counter_top #(
  parameter int unsigned MAX_COLUMNS = 4096,
  parameter int unsigned WINDOW_MAX  = 20,
  parameter int unsigned WINDOW_MIN  = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [iwrc_pkg::THRESH_W-1:0] cfg_wdata_i,
  iwrc_col_if.sink                      col_i,
  iwrc_res_if.source                    res_o
);

  localparam int unsigned RING  = WINDOW_MAX + 1;
  localparam int unsigned RW    = $clog2(RING);
  localparam int unsigned J_W   = $clog2(WINDOW_MAX + 1);
  localparam int unsigned PD_W  = $clog2(WINDOW_MAX + 2);
  localparam int unsigned CNT_W = $clog2(MAX_COLUMNS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_FIRST,
    ST_CAP_FIRST,
    ST_RD_PART,
    ST_LOAD,
    ST_CHECK,
    ST_FLUSH,
    ST_EMIT
  } state_e;

  state_e                        state_q, state_d;
  logic [CNT_W-1:0]              kept_q, kept_d;
  logic                          ovf_q, ovf_d;
  logic [PD_W-1:0]               pend_q, pend_d;
  logic [RW-1:0]                 wr_idx_q, wr_idx_d;
  logic [RW-1:0]                 jdg_idx_q, jdg_idx_d;
  logic [J_W-1:0]                j_q, j_d;
  logic                          flush_q, flush_d;
  logic [iwrc_pkg::THRESH_W-1:0] thr_q;
  logic                          out_valid_q, out_valid_d;
  logic [iwrc_pkg::COUNT_W-1:0]  out_count_q, out_count_d;
  logic                          out_ovf_q, out_ovf_d;

  logic                  ram_we, ram_re;
  logic [RW-1:0]         ram_waddr, ram_raddr;
  logic [CNT_W-1:0]      ram_wdata, ram_rdata;
  iwrc_pkg::judge_ctrl_t jctrl;
  logic                  pass;
  logic [CNT_W-1:0]      tagged_cnt;
  logic                  accept, is_match, out_free;
  logic [RW-1:0]         wr_next, jdg_next;
  logic [RW:0]           part_sum;
  logic [RW-1:0]         part_idx;
  logic [J_W-1:0]        j_start;
  logic                  j_none;

  assign accept   = col_i.valid && col_i.ready;
  assign is_match = col_i.present_a && col_i.present_b && (col_i.symbol_a == col_i.symbol_b);
  assign out_free = !out_valid_q || res_o.ready;
  assign wr_next  = (wr_idx_q == RW'(RING - 1)) ? '0 : wr_idx_q + RW'(1);
  assign jdg_next = (jdg_idx_q == RW'(RING - 1)) ? '0 : jdg_idx_q + RW'(1);
  assign part_sum = {1'b0, jdg_idx_q} + (RW + 1)'(j_q);
  assign part_idx = (part_sum >= (RW + 1)'(RING)) ? RW'(part_sum - (RW + 1)'(RING))
                                                   : RW'(part_sum);
  // Widest partner available is the newest match, pend - 1 places ahead.
  assign j_start  = (int'(pend_q) - 1 >= int'(WINDOW_MAX)) ? J_W'(WINDOW_MAX)
                                                           : J_W'(pend_q - PD_W'(1));
  assign j_none   = int'(j_start) < int'(WINDOW_MIN);

  assign col_i.ready = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    kept_d      = kept_q;
    ovf_d       = ovf_q;
    pend_d      = pend_q;
    wr_idx_d    = wr_idx_q;
    jdg_idx_d   = jdg_idx_q;
    j_d         = j_q;
    flush_d     = flush_q;
    out_valid_d = out_valid_q && !res_o.ready;
    out_count_d = out_count_q;
    out_ovf_d   = out_ovf_q;
    ram_we      = 1'b0;
    ram_waddr   = wr_next;
    ram_wdata   = kept_q + CNT_W'(1);
    ram_re      = 1'b0;
    ram_raddr   = jdg_idx_q;
    jctrl       = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (col_i.present_a || col_i.present_b) begin
            if (kept_q >= CNT_W'(MAX_COLUMNS)) begin
              ovf_d = 1'b1;
            end else begin
              kept_d = kept_q + CNT_W'(1);
              if (is_match) begin
                ram_we   = 1'b1;
                wr_idx_d = wr_next;
                pend_d   = pend_q + PD_W'(1);
              end
            end
          end
          flush_d = col_i.last_column;
          if (int'(pend_d) > int'(WINDOW_MAX)) begin
            state_d = ST_RD_FIRST;
          end else if (col_i.last_column) begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_RD_FIRST: begin
        if (j_none) begin
          pend_d    = pend_q - PD_W'(1);
          jdg_idx_d = jdg_next;
          state_d   = flush_q ? ST_FLUSH : ST_IDLE;
        end else begin
          ram_re  = 1'b1;
          j_d     = j_start;
          state_d = ST_CAP_FIRST;
        end
      end
      ST_CAP_FIRST: begin
        jctrl.first_en = 1'b1;
        ram_re         = 1'b1;
        ram_raddr      = part_idx;
        state_d        = ST_LOAD;
      end
      ST_RD_PART: begin
        ram_re    = 1'b1;
        ram_raddr = part_idx;
        state_d   = ST_LOAD;
      end
      ST_LOAD: begin
        jctrl.last_en = 1'b1;
        state_d       = ST_CHECK;
      end
      ST_CHECK: begin
        jctrl.check_en = 1'b1;
        if (pass || int'(j_q) <= int'(WINDOW_MIN)) begin
          pend_d    = pend_q - PD_W'(1);
          jdg_idx_d = jdg_next;
          state_d   = flush_q ? ST_FLUSH : ST_IDLE;
        end else begin
          j_d     = j_q - J_W'(1);
          state_d = ST_RD_PART;
        end
      end
      ST_FLUSH: begin
        state_d = (pend_q != '0) ? ST_RD_FIRST : ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_count_d = iwrc_pkg::COUNT_W'(tagged_cnt);
          out_ovf_d   = ovf_q;
          jctrl.clear = 1'b1;
          kept_d      = '0;
          ovf_d       = 1'b0;
          pend_d      = '0;
          wr_idx_d    = '0;
          jdg_idx_d   = RW'(1);
          flush_d     = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      kept_q      <= '0;
      ovf_q       <= 1'b0;
      pend_q      <= '0;
      wr_idx_q    <= '0;
      jdg_idx_q   <= RW'(1);
      j_q         <= '0;
      flush_q     <= 1'b0;
      thr_q       <= iwrc_pkg::THRESH_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      kept_q      <= kept_d;
      ovf_q       <= ovf_d;
      pend_q      <= pend_d;
      wr_idx_q    <= wr_idx_d;
      jdg_idx_q   <= jdg_idx_d;
      j_q         <= j_d;
      flush_q     <= flush_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_count_q <= out_count_d;
    out_ovf_q   <= out_ovf_d;
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.tagged_count    = out_count_q;
  assign res_o.column_overflow = out_ovf_q;

  iwrc_ram #(
    .WIDTH (CNT_W),
    .DEPTH (RING)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  iwrc_judge #(
    .CNT_W (CNT_W),
    .J_W   (J_W)
  ) u_judge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (jctrl),
    .rdata_i  (ram_rdata),
    .j_i      (j_q),
    .thr_i    (thr_q),
    .pass_o   (pass),
    .tagged_o (tagged_cnt)
  );

  // The ring holds at most one window of unjudged matches plus the newest.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(pend_q) <= int'(WINDOW_MAX) + 1)
    else $error("unjudged match count exceeds ring depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(kept_q) <= int'(MAX_COLUMNS))
    else $error("kept column count beyond limit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD) |-> (int'(j_q) >= int'(WINDOW_MIN) && int'(j_q) <= int'(WINDOW_MAX)))
    else $error("window width out of range during judgement");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_EMIT))
    else $error("result raised outside the emit step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && out_free) |=> (kept_q == '0 && pend_q == '0 && !ovf_q))
    else $error("run state not cleared after result");

endmodule

### test/iwrc_tally_checker.sv
// Checker for the identity window residue counter: predicts every count word and compares.
module iwrc_tally_checker #(
  parameter int unsigned MAX_COLUMNS = 4096,
  parameter int unsigned WINDOW_MAX  = 20,
  parameter int unsigned WINDOW_MIN  = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [iwrc_pkg::THRESH_W-1:0] cfg_wdata_i,
  iwrc_col_if                           col_i,
  iwrc_res_if                           res_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o,
  output int unsigned                   checked_o
);

  localparam int unsigned RING_DEPTH = WINDOW_MAX + 1;

  typedef struct packed {
    logic [iwrc_pkg::COUNT_W-1:0] count;
    logic                         overflow;
  } tally_t;

  logic [iwrc_pkg::COUNT_W-1:0]  match_pos [RING_DEPTH];
  logic [iwrc_pkg::COUNT_W-1:0]  kept_cols;
  logic [iwrc_pkg::COUNT_W-1:0]  match_cnt;
  logic [iwrc_pkg::COUNT_W-1:0]  next_judged;
  logic [iwrc_pkg::COUNT_W-1:0]  covered_end;
  logic [iwrc_pkg::COUNT_W-1:0]  covered_cols;
  logic                          too_many;
  logic [iwrc_pkg::THRESH_W-1:0] threshold;
  tally_t                        expected_tallies [$];
  int unsigned                   fails = 0;
  int unsigned                   checked = 0;

  assign fail_count_o = fails;
  assign checked_o    = checked;

  task automatic report(input string what, input int unsigned want, input int unsigned got);
    fails++;
    $display("MISMATCH at %0t, count word %0d: %s expected %0d, got %0d",
             $time, checked, what, want, got);
  endtask

  task automatic queue_tally(input tally_t entry);
    expected_tallies = {expected_tallies, entry};
  endtask

  task automatic restart_alignment();
    foreach (match_pos[k]) match_pos[k] = '0;
    kept_cols    = '0;
    match_cnt    = '0;
    next_judged  = iwrc_pkg::COUNT_W'(1);
    covered_end  = '0;
    covered_cols = '0;
    too_many     = 1'b0;
  endtask

  // Tries the widest window first; the first one dense enough marks its columns.
  task automatic settle_match(input int unsigned m, input int unsigned limit);
    int          w;
    int unsigned first_col;
    int unsigned last_col;
    int unsigned span;
    logic [63:0] lhs;
    logic [63:0] rhs;
    bit          found;
    found = 1'b0;
    for (w = WINDOW_MAX; w >= int'(WINDOW_MIN) && !found; w--) begin
      if (m + w <= limit) begin
        first_col = 32'(match_pos[m % RING_DEPTH]);
        last_col  = 32'(match_pos[(m + w) % RING_DEPTH]);
        span      = last_col - first_col + 1;
        lhs       = 64'(w + 1) << 16;
        rhs       = 64'(threshold) * 64'(span);
        if (lhs > rhs) begin
          // Windows are judged in order, so only the part past covered_end is new.
          if (last_col > covered_end) begin
            covered_cols = iwrc_pkg::COUNT_W'(covered_cols + last_col -
                           ((first_col > covered_end) ? first_col : covered_end + 1) + 1);
            covered_end  = iwrc_pkg::COUNT_W'(last_col);
          end
          found = 1'b1;
        end
      end
    end
  endtask

  task automatic take_column(input logic pa, input logic pb,
                             input logic [iwrc_pkg::SYMBOL_W-1:0] sa,
                             input logic [iwrc_pkg::SYMBOL_W-1:0] sb, input logic last_col);
    tally_t result;
    if (pa || pb) begin
      if (kept_cols >= MAX_COLUMNS) begin
        too_many = 1'b1;
      end else begin
        kept_cols++;
        if (pa && pb && sa == sb) begin
          match_cnt++;
          match_pos[match_cnt % RING_DEPTH] = kept_cols;
          if (match_cnt >= next_judged + WINDOW_MAX) begin
            settle_match(32'(next_judged), 32'(match_cnt));
            next_judged++;
          end
        end
      end
    end
    if (last_col) begin
      while (next_judged <= match_cnt) begin
        settle_match(32'(next_judged), 32'(match_cnt));
        next_judged++;
      end
      result.count    = covered_cols;
      result.overflow = too_many;
      queue_tally(result);
      restart_alignment();
    end
  endtask

  task automatic check_tally();
    tally_t want;
    checked++;
    if (expected_tallies.size() == 0) begin
      report("count word with nothing expected, tagged_count", 0,
             32'(res_i.tagged_count));
    end else begin
      want = expected_tallies.pop_front();
      if (res_i.tagged_count !== want.count)
        report("tagged_count", 32'(want.count), 32'(res_i.tagged_count));
      if (res_i.column_overflow !== want.overflow)
        report("column_overflow", 32'(want.overflow), 32'(res_i.column_overflow));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_tallies.delete();
      threshold = iwrc_pkg::THRESH_RESET;
      restart_alignment();
      pending_o <= 0;
    end else begin
      if (res_i.valid && res_i.ready) check_tally();
      if (cfg_we_i) threshold = cfg_wdata_i;
      if (col_i.valid && col_i.ready)
        take_column(col_i.present_a, col_i.present_b, col_i.symbol_a, col_i.symbol_b,
                    col_i.last_column);
      pending_o <= expected_tallies.size();
    end
  end

endmodule

### test/tb.sv
// Testbench top: drives alignment columns and thresholds into the counter and gives the verdict.
module tb;

  localparam int unsigned MAX_COLUMNS   = 4096;
  localparam int unsigned WINDOW_MAX    = 20;
  localparam int unsigned WINDOW_MIN    = 4;
  localparam int unsigned IDLE_LIMIT    = 20000;
  localparam int unsigned HOLD_CYCLES   = 600;
  localparam int unsigned SETTLE_CYCLES = 60;
  localparam int unsigned DRAIN_CYCLES  = 200;
  localparam int unsigned PHASE_COLUMNS = 140;
  localparam int unsigned NUM_PHASES    = 8;

  typedef enum logic [2:0] {
    COL_MATCH, COL_MISMATCH, COL_ONLY_A, COL_ONLY_B, COL_EMPTY
  } column_kind_e;

  typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_e;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [iwrc_pkg::THRESH_W-1:0] cfg_wdata_i;

  iwrc_col_if col_if ();
  iwrc_res_if res_if ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;

  int unsigned columns_sent    = 0;
  int unsigned alignments_sent = 0;
  int unsigned settings_used   = 0;
  int unsigned burst_left      = 0;
  bit          gaps_on         = 1'b0;
  int unsigned hold_requests   = 0;
  rx_mode_e    rx_mode         = RX_ALWAYS;
  int unsigned idle_cycles     = 0;

  identity_window_residue_counter_top #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .WINDOW_MAX  (WINDOW_MAX),
    .WINDOW_MIN  (WINDOW_MIN)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .col_i       (col_if),
    .res_o       (res_if)
  );

  iwrc_tally_checker #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .WINDOW_MAX  (WINDOW_MAX),
    .WINDOW_MIN  (WINDOW_MIN)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .col_i        (col_if),
    .res_i        (res_if),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Receiver: ready mode chosen per phase (always, random or patterned stalls), plus a long hold-off on request.
  initial begin
    int unsigned tick;
    int unsigned holds_done;
    tick       = 0;
    holds_done = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      tick++;
      if (hold_requests != holds_done) begin
        holds_done++;
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        case (rx_mode)
          RX_ALWAYS: res_if.ready <= 1'b1;
          RX_RANDOM: res_if.ready <= ($urandom_range(0, 99) >= 35);
          default:   res_if.ready <= ((tick % 5) >= 3);
        endcase
      end
    end
  end

  // Nothing accepted on either channel for too long means the block has hung.
  always @(posedge clk_i) begin
    if (!rst_ni || (col_if.valid && col_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog: no word accepted for %0d cycles", IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_word(input logic pa, input logic pb,
                           input logic [iwrc_pkg::SYMBOL_W-1:0] sa,
                           input logic [iwrc_pkg::SYMBOL_W-1:0] sb, input logic last_col);
    col_if.valid       <= 1'b1;
    col_if.present_a   <= pa;
    col_if.present_b   <= pb;
    col_if.symbol_a    <= sa;
    col_if.symbol_b    <= sb;
    col_if.last_column <= last_col;
    do begin
      @(posedge clk_i);
    end while (!col_if.ready);
    columns_sent++;
    if (last_col) alignments_sent++;
    if (gaps_on) begin
      if (burst_left > 1) begin
        burst_left--;
      end else begin
        col_if.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        burst_left = $urandom_range(1, 40);
      end
    end
  endtask

  task automatic put_column(input column_kind_e kind, input logic last_col);
    logic [iwrc_pkg::SYMBOL_W-1:0] sa;
    logic [iwrc_pkg::SYMBOL_W-1:0] sb;
    sa = iwrc_pkg::SYMBOL_W'($urandom_range(0, 255));
    sb = iwrc_pkg::SYMBOL_W'($urandom_range(0, 255));
    if (kind == COL_MATCH) sb = sa;
    if (kind == COL_MISMATCH && sb == sa)
      sb = sa ^ iwrc_pkg::SYMBOL_W'(1 << $urandom_range(0, 7));
    send_word(kind != COL_ONLY_B && kind != COL_EMPTY, kind != COL_ONLY_A && kind != COL_EMPTY,
              sa, sb, last_col);
  endtask

  task automatic run_alignment(input int unsigned len, input int unsigned match_pct,
                               input int unsigned empty_pct);
    int unsigned  r;
    column_kind_e kind;
    for (int unsigned i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (r < empty_pct)
        kind = COL_EMPTY;
      else if (r < empty_pct + match_pct)
        kind = COL_MATCH;
      else
        kind = column_kind_e'($urandom_range(COL_MISMATCH, COL_ONLY_B));
      put_column(kind, i == len - 1);
    end
  endtask

  // The counter is only idle once every count word is back and its judge has settled.
  task automatic quiesce();
    col_if.valid <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [iwrc_pkg::THRESH_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    settings_used++;
  endtask

  initial begin
    int unsigned                   phase_start;
    int unsigned                   len;
    int unsigned                   empty_pct;
    int unsigned                   match_pct;
    logic [iwrc_pkg::THRESH_W-1:0] thr;

    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_wdata_i        <= '0;
    col_if.valid       <= 1'b0;
    col_if.present_a   <= 1'b0;
    col_if.present_b   <= 1'b0;
    col_if.symbol_a    <= '0;
    col_if.symbol_b    <= '0;
    col_if.last_column <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed alignments at the reset threshold.
    send_word(1'b0, 1'b0, 8'hFF, 8'h00, 1'b1);
    send_word(1'b1, 1'b1, 8'h00, 8'h00, 1'b0);
    send_word(1'b1, 1'b1, 8'hFF, 8'hFF, 1'b0);
    send_word(1'b1, 1'b1, 8'h00, 8'hFF, 1'b0);
    send_word(1'b1, 1'b0, 8'hAA, 8'h55, 1'b0);
    send_word(1'b0, 1'b1, 8'h55, 8'hAA, 1'b0);
    send_word(1'b1, 1'b1, 8'hAA, 8'hAA, 1'b0);
    send_word(1'b0, 1'b0, 8'hFF, 8'hFF, 1'b0);
    send_word(1'b1, 1'b1, 8'h55, 8'h55, 1'b0);
    send_word(1'b1, 1'b1, 8'h0F, 8'h0F, 1'b0);
    send_word(1'b1, 1'b1, 8'hF0, 8'hF0, 1'b0);
    send_word(1'b0, 1'b0, 8'h00, 8'h00, 1'b1);
    for (int k = 0; k < 4; k++) send_word(1'b1, 1'b1, 8'h3C, 8'h3C, k == 3);
    send_word(1'b1, 1'b0, 8'h81, 8'h7E, 1'b1);
    quiesce();

    // Hold the result side off while columns keep coming, so the block backs up.
    hold_requests <= hold_requests + 1;
    repeat (6) run_alignment(10, 100, 0);
    quiesce();

    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       thr = 16'h0000;
        1:       thr = 16'hFFFF;
        2:       thr = iwrc_pkg::THRESH_RESET;
        3:       thr = 16'h0001;
        4:       thr = 16'h8000;
        7:       thr = 16'hCCCC;
        default: thr = iwrc_pkg::THRESH_W'($urandom_range(0, 65535));
      endcase
      write_threshold(thr);
      rx_mode    <= rx_mode_e'(p % 3);
      gaps_on    = (p % 4 != 1);
      burst_left = $urandom_range(1, 40);
      phase_start = columns_sent;
      while (columns_sent - phase_start < PHASE_COLUMNS) begin
        len       = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                : $urandom_range(1, 50);
        empty_pct = $urandom_range(0, 15);
        // Mostly dense alignments so that windows qualify, some sparse noise.
        match_pct = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 20)
                                                : $urandom_range(30, 100 - empty_pct);
        run_alignment(len, match_pct, empty_pct);
      end
      quiesce();
    end

    write_threshold(iwrc_pkg::THRESH_RESET);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Checked %0d count words from %0d alignments (%0d columns) over %0d thresholds,",
             checked, alignments_sent, columns_sent, settings_used);
    $display("with idle gaps, result stalls, a long hold-off and extreme thresholds.");
    if (fail_count == 0 && pending == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
